@@ rtl/core/nmso_pkg.sv @@
`default_nettype none
package nmso_pkg;

    // Parameter defaults
    localparam int ROWS_DEF   = 32;
    localparam int TRACKS_DEF = 8;

    // Fixed field widths
    localparam int NOTE_W      = 7;
    localparam int TRACK_W     = 8;
    localparam int TRK_FIELD_W = 3;   // enough for any track index below 8
    localparam int ROW_BITS_W  = 8;

    // Register indexes (paddr[2])
    localparam logic REG_NOTE_OFFSET = 1'b0;
    localparam logic REG_METRONOME   = 1'b1;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_UPDATE   = 3'd2,
        CMD_PANIC    = 3'd3,
        CMD_SILENCE  = 3'd4,
        CMD_CLICK    = 3'd5
    } cmd_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SHIFT = 2'd0,
        KIND_LATCH = 2'd1,
        KIND_CLICK = 2'd2
    } kind_t;

    // Work handed from front to back
    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_UPDATE,
        OP_PANIC,
        OP_SILENCE,
        OP_CLICK
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [NOTE_W-1:0]      row;
        logic [TRK_FIELD_W-1:0] trk;
    } entry_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_NOTE_RD,
        B_NOTE_WR,
        B_WALK_RD,
        B_WALK_PUT,
        B_LATCH,
        B_CLICK
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/nmso_front.sv @@
`default_nettype none
module nmso_front #(
    parameter int ROWS   = nmso_pkg::ROWS_DEF,
    parameter int TRACKS = nmso_pkg::TRACKS_DEF
) (
    input  wire logic [2:0]                   command,
    input  wire logic [nmso_pkg::TRACK_W-1:0] track,
    input  wire logic [nmso_pkg::NOTE_W-1:0]  note,
    input  wire logic [nmso_pkg::NOTE_W-1:0]  note_offset,
    input  wire logic                         metronome_enable,
    output nmso_pkg::entry_t                  entry,
    output logic                              entry_keep
);

    logic [nmso_pkg::NOTE_W:0] diff;
    logic                      note_ok;

    // Shifted note and range checks
    assign diff    = {1'b0, note} - {1'b0, note_offset};
    assign note_ok = !diff[nmso_pkg::NOTE_W]
                     && (diff[nmso_pkg::NOTE_W-1:0] < nmso_pkg::NOTE_W'(ROWS))
                     && (track < nmso_pkg::TRACK_W'(TRACKS));

    // Classify the beat; dropped beats never reach the queue
    always_comb
    begin
        entry.row  = diff[nmso_pkg::NOTE_W-1:0];
        entry.trk  = track[nmso_pkg::TRK_FIELD_W-1:0];
        entry.op   = nmso_pkg::OP_UPDATE;
        entry_keep = 1'b0;
        case (nmso_pkg::cmd_t'(command))
            nmso_pkg::CMD_NOTE_ON:
            begin
                entry.op   = nmso_pkg::OP_SET;
                entry_keep = note_ok;
            end
            nmso_pkg::CMD_NOTE_OFF:
            begin
                entry.op   = nmso_pkg::OP_CLR;
                entry_keep = note_ok;
            end
            nmso_pkg::CMD_UPDATE:
            begin
                entry.op   = nmso_pkg::OP_UPDATE;
                entry_keep = 1'b1;
            end
            nmso_pkg::CMD_PANIC:
            begin
                entry.op   = nmso_pkg::OP_PANIC;
                entry_keep = 1'b1;
            end
            nmso_pkg::CMD_SILENCE:
            begin
                entry.op   = nmso_pkg::OP_SILENCE;
                entry_keep = 1'b1;
            end
            nmso_pkg::CMD_CLICK:
            begin
                entry.op   = nmso_pkg::OP_CLICK;
                entry_keep = metronome_enable;
            end
            default:
            begin
                entry_keep = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/nmso_fifo.sv @@
`default_nettype none
module nmso_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire nmso_pkg::entry_t push_data,
    input  wire logic             pop,
    output nmso_pkg::entry_t      head,
    output logic                  full,
    output logic                  empty
);

    nmso_pkg::entry_t buf_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = buf_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

@@ rtl/core/nmso_back.sv @@
`default_nettype none
module nmso_back #(
    parameter int ROWS   = nmso_pkg::ROWS_DEF,
    parameter int TRACKS = nmso_pkg::TRACKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire nmso_pkg::entry_t                head,
    input  wire logic                            empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           kind,
    output logic [nmso_pkg::ROW_BITS_W-1:0]      row_bits,
    output logic                                 last
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    nmso_pkg::back_state_t state_reg, state_next;
    nmso_pkg::op_t         op_reg;
    logic [RW-1:0]         row_reg;
    logic [TW-1:0]         trk_reg;
    logic [RW-1:0]         cnt_reg, cnt_next;

    // Matrix storage with per-row valid bits
    logic [TRACKS-1:0]     row_mem_reg [ROWS];
    logic [ROWS-1:0]       valid_reg;
    logic [TRACKS-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [TRACKS-1:0]     cur_row;

    // Output register
    logic                  out_valid_reg;
    nmso_pkg::kind_t       kind_reg, kind_next;
    logic [nmso_pkg::ROW_BITS_W-1:0] bits_reg, bits_next;
    logic                  last_reg, last_next;
    logic                  out_load;
    logic                  out_free;

    logic                  rd_en;
    logic [RW-1:0]         rd_addr;
    logic                  wr_en;
    logic [TRACKS-1:0]     wr_data;
    logic                  clr_all;
    logic [TRACKS-1:0]     bit_mask;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_row   = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask  = TRACKS'(1) << trk_reg;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign row_bits  = bits_reg;
    assign last      = last_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg;
        wr_en      = 1'b0;
        wr_data    = cur_row;
        clr_all    = 1'b0;
        out_load   = 1'b0;
        kind_next  = nmso_pkg::KIND_SHIFT;
        bits_next  = '0;
        last_next  = 1'b0;
        case (state_reg)
            nmso_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cnt_next = '0;
                    case (head.op)
                        nmso_pkg::OP_SET,
                        nmso_pkg::OP_CLR:   state_next = nmso_pkg::B_NOTE_RD;
                        nmso_pkg::OP_CLICK: state_next = nmso_pkg::B_CLICK;
                        nmso_pkg::OP_PANIC:
                        begin
                            clr_all    = 1'b1;
                            state_next = nmso_pkg::B_WALK_RD;
                        end
                        default:            state_next = nmso_pkg::B_WALK_RD;
                    endcase
                end
            end
            nmso_pkg::B_NOTE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = row_reg;
                state_next = nmso_pkg::B_NOTE_WR;
            end
            nmso_pkg::B_NOTE_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = (op_reg == nmso_pkg::OP_SET) ? (cur_row | bit_mask)
                                                           : (cur_row & ~bit_mask);
                state_next = nmso_pkg::B_IDLE;
            end
            nmso_pkg::B_WALK_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                state_next = nmso_pkg::B_WALK_PUT;
            end
            nmso_pkg::B_WALK_PUT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    kind_next = nmso_pkg::KIND_SHIFT;
                    bits_next = (op_reg == nmso_pkg::OP_SILENCE) ? '0
                              : nmso_pkg::ROW_BITS_W'(cur_row);
                    if (cnt_reg == RW'(ROWS - 1))
                        state_next = nmso_pkg::B_LATCH;
                    else
                    begin
                        cnt_next   = cnt_reg + RW'(1);
                        state_next = nmso_pkg::B_WALK_RD;
                    end
                end
            end
            nmso_pkg::B_LATCH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = nmso_pkg::KIND_LATCH;
                    last_next  = 1'b1;
                    state_next = nmso_pkg::B_IDLE;
                end
            end
            nmso_pkg::B_CLICK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = nmso_pkg::KIND_CLICK;
                    last_next  = 1'b1;
                    state_next = nmso_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = nmso_pkg::B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nmso_pkg::B_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (clr_all)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[row_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg  <= head.op;
            row_reg <= head.row[RW-1:0];
            trk_reg <= head.trk[TW-1:0];
        end
        if (out_load)
        begin
            kind_reg <= kind_next;
            bits_reg <= bits_next;
            last_reg <= last_next;
        end
    end

    // Matrix memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem_reg[row_reg] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= row_mem_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/note_matrix_shift_out_top.sv @@
// Note matrix driving a chain of shift registers.
// Input channel (in_valid / in_stall) carries command, track and note beats.
// Note-on/off set or clear one bit at row note - note_offset, column track;
// out-of-range notes or tracks, unknown commands and clicks with the
// metronome off are dropped at the front and produce no result.
// Output channel (out_valid / out_stall) carries kind, row_bits and last.
// Update, panic and silence produce ROWS shift beats (row 0 first) and a
// latch beat with last set; an enabled click gives one buzzer beat.
// Accepted beats go through a two-entry queue, so the input is stalled only
// when that queue is full. A note command costs the back end one matrix read
// and one write; a row walk outputs every row and then the latch beat, and a
// click loads one beat; each row costs one matrix read and one output load.
// With the back end idle and the output free, a walk pops, reads row 0 and
// registers it; a click pops and registers its beat. A stalled output holds
// its beat and pauses the walk; the queue keeps filling meanwhile. Reset
// clears the matrix (per-row valid bits), note_offset and metronome_enable.
// Registers are to be written over the APB port only while idle; the block
// itself does not enforce this.
`default_nettype none
module note_matrix_shift_out_top #(
    parameter int ROWS   = nmso_pkg::ROWS_DEF,
    parameter int TRACKS = nmso_pkg::TRACKS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // Input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       command,
    input  wire logic [nmso_pkg::TRACK_W-1:0]     track,
    input  wire logic [nmso_pkg::NOTE_W-1:0]      note,
    // Output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            kind,
    output logic [nmso_pkg::ROW_BITS_W-1:0]       row_bits,
    output logic                                  last
);

    logic [nmso_pkg::NOTE_W-1:0] note_offset_reg;
    logic                        metronome_reg;
    logic                        cfg_wr;

    nmso_pkg::entry_t            entry;
    logic                        entry_keep;
    nmso_pkg::entry_t            head;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    logic                        q_push;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_offset_reg <= '0;
            metronome_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                nmso_pkg::REG_NOTE_OFFSET:
                    note_offset_reg <= pwdata[nmso_pkg::NOTE_W-1:0];
                nmso_pkg::REG_METRONOME:
                    metronome_reg <= pwdata[0];
                default:
                    metronome_reg <= metronome_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            nmso_pkg::REG_NOTE_OFFSET: prdata = 32'(note_offset_reg);
            nmso_pkg::REG_METRONOME:   prdata = 32'(metronome_reg);
            default:                   prdata = '0;
        endcase
    end

    // Front: classify and drop
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && entry_keep;

    nmso_front #(
        .ROWS   (ROWS),
        .TRACKS (TRACKS)
    ) u_front (
        .command          (command),
        .track            (track),
        .note             (note),
        .note_offset      (note_offset_reg),
        .metronome_enable (metronome_reg),
        .entry            (entry),
        .entry_keep       (entry_keep)
    );

    nmso_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (entry),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: matrix and result sequencing
    nmso_back #(
        .ROWS   (ROWS),
        .TRACKS (TRACKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .row_bits  (row_bits),
        .last      (last)
    );

endmodule
`default_nettype wire
